// ===== rtl/pru_pkg.sv =====
// Shared types and constants of the pixel replicate upscaler.
// No dependencies; imported by pru_front, pru_queue and the top level.
package pru_pkg;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_STORED  = 3'd0;
    localparam t_status ST_PIXEL   = 3'd1;
    localparam t_status ST_PAD     = 3'd2;
    localparam t_status ST_EMPTY   = 3'd3;
    localparam t_status ST_REFUSED = 3'd4;

    // input opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index REG_SCALE = 1'd0;
    localparam t_cfg_index REG_WIDTH = 1'd1;

    localparam int CFG_DATA_W = 13;
    localparam int SCALE_W    = 7;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;
    localparam int PIXEL_W    = 24;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified item leaving the front
    typedef struct packed {
        t_status status;
        logic    is_pixel;
        logic    row_end;
        logic    replay_end;
    } t_cmd;

    // finished result beat
    typedef struct packed {
        t_status    status;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       replay_end;
    } t_beat;

endpackage

// ===== rtl/pru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pru_front.sv =====
// Front part: accepts items, runs the fill/replay counters, drives the
// line store ports and registers the classified item. Uses pru_pkg.
module pru_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [pru_pkg::SCALE_W-1:0]                 i_scale,
    input  logic [pru_pkg::CFG_DATA_W-1:0]              i_width,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_opcode,
    input  logic [7:0]                                  i_blue,
    input  logic [7:0]                                  i_green,
    input  logic [7:0]                                  i_red,
    input  logic                                        i_room,
    output logic                                        o_ram_we,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_ram_waddr,
    output logic [pru_pkg::PIXEL_W-1:0]                 o_ram_wdata,
    output logic                                        o_ram_re,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_ram_raddr,
    output logic                                        o_cmd_valid,
    output pru_pkg::t_cmd                               o_cmd
);
    import pru_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]      r_fill, n_fill;
    logic               r_row_ready, n_row_ready;
    logic [AW-1:0]      r_col, n_col;
    logic [SCALE_W-1:0] r_hrep, n_hrep;
    logic [SCALE_W-1:0] r_vrep, n_vrep;
    logic [1:0]         r_pad_left, n_pad_left;
    logic               r_in_padding, n_in_padding;
    logic               r_cmd_valid;
    t_cmd               r_cmd, n_cmd;

    logic               accept;
    logic [SCALE_W-1:0] eff_scale;
    logic [CW-1:0]      eff_width;
    logic [CW+1:0]      width_wide;
    logic [3:0]         low_prod;
    logic [1:0]         pad_bytes;
    logic [CW-1:0]      fill_inc;
    logic [CW-1:0]      col_inc;
    logic [SCALE_W:0]   hrep_inc;
    logic [SCALE_W:0]   vrep_inc;
    logic [1:0]         pad_dec;
    logic               do_finish;

    assign o_in_stall = !i_room;
    assign accept     = i_in_valid && !o_in_stall;

    // clamp registers to their working ranges
    always_comb begin
        priority if (i_scale == '0) begin
            eff_scale = SCALE_W'(1);
        end else if (i_scale > SCALE_MAX) begin
            eff_scale = SCALE_MAX;
        end else begin
            eff_scale = i_scale;
        end
        priority if (i_width == '0) begin
            eff_width = CW'(1);
        end else if (32'(i_width) > MAX_WIDTH) begin
            eff_width = CW'(MAX_WIDTH);
        end else begin
            eff_width = CW'(i_width);
        end
    end

    // padding to a 4-byte boundary only depends on the two low bits
    assign width_wide = (CW+2)'(eff_width);
    assign low_prod   = 4'(width_wide[1:0]) * 4'(eff_scale[1:0]);
    assign pad_bytes  = 2'd0 - 2'(low_prod * 4'd3);

    assign fill_inc = r_fill + CW'(1);
    assign col_inc  = CW'(r_col) + CW'(1);
    assign hrep_inc = {1'b0, r_hrep} + (SCALE_W+1)'(1);
    assign vrep_inc = {1'b0, r_vrep} + (SCALE_W+1)'(1);
    assign pad_dec  = (r_pad_left != 2'd0) ? r_pad_left - 2'd1 : 2'd0;

    // item classification and counter update
    always_comb begin
        n_fill       = r_fill;
        n_row_ready  = r_row_ready;
        n_col        = r_col;
        n_hrep       = r_hrep;
        n_vrep       = r_vrep;
        n_pad_left   = r_pad_left;
        n_in_padding = r_in_padding;
        n_cmd        = '0;
        do_finish    = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_re     = 1'b0;

        if (accept) begin
            if (i_opcode == OP_PUSH) begin
                n_cmd.status = ST_REFUSED;
                if (!r_row_ready) begin
                    if (r_fill >= eff_width) begin
                        n_row_ready = 1'b1;
                        n_fill      = '0;
                        n_col       = '0;
                        n_hrep      = '0;
                        n_vrep      = '0;
                    end else begin
                        o_ram_we     = 1'b1;
                        n_cmd.status = ST_STORED;
                        if (fill_inc >= eff_width) begin
                            n_row_ready = 1'b1;
                            n_fill      = '0;
                            n_col       = '0;
                            n_hrep      = '0;
                            n_vrep      = '0;
                        end else begin
                            n_fill = fill_inc;
                        end
                    end
                end
            end else if (!r_row_ready) begin
                n_cmd.status = ST_EMPTY;
            end else if (r_in_padding) begin
                n_cmd.status = ST_PAD;
                n_pad_left   = pad_dec;
                if (pad_dec == 2'd0) begin
                    n_in_padding  = 1'b0;
                    n_cmd.row_end = 1'b1;
                    do_finish     = 1'b1;
                end
            end else begin
                n_cmd.status   = ST_PIXEL;
                n_cmd.is_pixel = 1'b1;
                o_ram_re       = 1'b1;
                if (hrep_inc >= {1'b0, eff_scale}) begin
                    n_hrep = '0;
                    if (col_inc >= eff_width) begin
                        n_col = '0;
                        if (pad_bytes != 2'd0) begin
                            n_in_padding = 1'b1;
                            n_pad_left   = pad_bytes;
                        end else begin
                            n_cmd.row_end = 1'b1;
                            do_finish     = 1'b1;
                        end
                    end else begin
                        n_col = AW'(col_inc);
                    end
                end else begin
                    n_hrep = SCALE_W'(hrep_inc);
                end
            end

            // end of one replica row
            if (do_finish) begin
                if (vrep_inc >= {1'b0, eff_scale}) begin
                    n_vrep           = '0;
                    n_row_ready      = 1'b0;
                    n_fill           = '0;
                    n_cmd.replay_end = 1'b1;
                end else begin
                    n_vrep = SCALE_W'(vrep_inc);
                end
            end
        end
    end

    assign o_ram_waddr = AW'(r_fill);
    assign o_ram_wdata = {i_red, i_green, i_blue};
    assign o_ram_raddr = r_col;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_row_ready  <= 1'b0;
            r_col        <= '0;
            r_hrep       <= '0;
            r_vrep       <= '0;
            r_pad_left   <= '0;
            r_in_padding <= 1'b0;
            r_cmd_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_row_ready  <= n_row_ready;
            r_col        <= n_col;
            r_hrep       <= n_hrep;
            r_vrep       <= n_vrep;
            r_pad_left   <= n_pad_left;
            r_in_padding <= n_in_padding;
            r_cmd_valid  <= accept;
        end
    end

    // classified item, aligned with the store read data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

    a_pad_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_padding |-> r_row_ready)
        else $error("padding active without a complete row");

    a_pad_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_padding |-> (r_pad_left == 2'd0))
        else $error("padding count left over outside padding");

    a_accept_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_cmd_valid && $past(o_ram_re) == r_cmd.is_pixel))
        else $error("accepted beat did not reach the back part");

endmodule

// ===== rtl/pru_queue.sv =====
// Back part: short result queue whose head drives the output channel.
// Uses pru_pkg for the beat type and queue sizing.
module pru_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pru_pkg::t_beat i_beat,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_stall,
    output pru_pkg::t_beat o_beat
);
    import pru_pkg::*;

    t_beat             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    // room for one more beat beyond any already in flight
    assign o_room  = ((QCNT_W+1)'(r_count) + (QCNT_W+1)'(i_push)) < (QCNT_W+1)'(QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH) || pop))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/pixel_replicate_upscaler.sv =====
// Integer-factor nearest-neighbor upscaler for 24-bit pixel rows.
// Top level: configuration registers, line store, front and back parts.
// Depends on pru_pkg, pru_ram, pru_front and pru_queue.
//
// Usage: write scale (index 0) and source_width (index 1) through the
// plain write port while the block is idle. Input beats carry an opcode:
// push stores one source pixel, pull asks for the next output item.
// Once source_width pixels are pushed, pulls return each pixel scale
// times, then zero padding bytes to a 4-byte boundary, and the row is
// replayed scale times. Every input beat yields one result beat with a
// status code and row_end / replay_end markers.
// A taken beat is registered as a classified item with the line store
// read, then written into the result queue, whose head drives the
// output. Throughput: one beat per cycle while the queue has room, set
// by the single line store port pair; pushes and pulls share no cycle.
// Reset (synchronous, active low) clears all counters, empties the
// result queue and sets scale and width to 1; line store contents stay.
// When the receiver stalls, the head beat holds; the four-entry queue
// absorbs beats in flight and the input stalls once it has no room left.
module pixel_replicate_upscaler #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  pru_pkg::t_cfg_index             i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_red,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic [7:0]                      o_out_blue,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_red,
    output logic                            o_row_end,
    output logic                            o_replay_end
);
    import pru_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [SCALE_W-1:0]    r_scale;
    logic [CFG_DATA_W-1:0] r_width;

    logic                  room;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [PIXEL_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [PIXEL_W-1:0]    ram_rdata;
    logic                  cmd_valid;
    t_cmd                  cmd;
    t_beat                 push_beat;
    t_beat                 head_beat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_WIDTH: r_width <= i_cfg_data;
                default:   r_width <= r_width;
            endcase
        end
    end

    pru_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_scale),
        .i_width     (r_width),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_room      (room),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // line store for one source row
    pru_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // merge pixel data into the result beat
    always_comb begin
        push_beat            = '0;
        push_beat.status     = cmd.status;
        push_beat.row_end    = cmd.row_end;
        push_beat.replay_end = cmd.replay_end;
        if (cmd.is_pixel) begin
            push_beat.blue  = ram_rdata[7:0];
            push_beat.green = ram_rdata[15:8];
            push_beat.red   = ram_rdata[23:16];
        end
    end

    pru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_beat  (push_beat),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (head_beat)
    );

    assign o_status     = head_beat.status;
    assign o_out_blue   = head_beat.blue;
    assign o_out_green  = head_beat.green;
    assign o_out_red    = head_beat.red;
    assign o_row_end    = head_beat.row_end;
    assign o_replay_end = head_beat.replay_end;

endmodule
